[sv/csws_pkg.sv]
// Shared types and constants for the chunked stop-and-wait sender.
// Used by csws_recip, csws_core and chunked_stop_and_wait_sender_top.
package csws_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ACK   = 2'd1,
    REQ_POLL  = 2'd2,
    REQ_LINK  = 2'd3
  } req_e;

  localparam logic        KIND_HDR  = 1'b0;
  localparam logic        KIND_DATA = 1'b1;
  localparam logic [15:0] SEQ_ANY   = 16'hFFFF;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned OUT_USER_W = 1;

  // Shift of the reciprocal used for the packet-count estimate.
  localparam int unsigned RECIP_SHIFT = 31;

  typedef struct packed {
    req_e        req;
    logic [23:0] len;
    logic [15:0] ack;
    logic        link;
    logic [24:0] quot_est;  // estimate of ceil(len / chunk), low by at most one
  } item_t;

  typedef struct packed {
    logic        pkt_valid;
    logic        pkt_kind;
    logic [15:0] pkt_seq;
    logic [23:0] pkt_offset;
    logic [7:0]  pkt_len;
    logic [23:0] hdr_length;
    logic [15:0] hdr_packets;
    logic        transfer_done;
    logic        busy_res;
    logic        awaiting_ack;
  } res_t;

endpackage

[sv/csws_recip.sv]
// Reciprocal multiply that estimates ceil(len / CHUNK_BYTES).
// Depends on csws_pkg for the reciprocal shift.
module csws_recip #(
  parameter int unsigned CHUNK_BYTES = 180
) (
  input  logic [23:0] len_i,
  output logic [24:0] quot_est_o
);

  localparam int unsigned S = csws_pkg::RECIP_SHIFT;
  localparam logic [31:0] RECIP = 32'((64'd1 << S) / CHUNK_BYTES);
  localparam logic [24:0] ROUND_UP = 25'(CHUNK_BYTES - 1);

  logic [24:0] dividend;
  logic [56:0] prod;

  assign dividend   = {1'b0, len_i} + ROUND_UP;
  assign prod       = 57'(dividend) * 57'(RECIP);
  assign quot_est_o = prod[S+24:S];

endmodule

[sv/csws_core.sv]
// Transfer state and per-beat step of the chunked stop-and-wait sender.
// Depends on csws_pkg for the item and result types and request codes.
module csws_core #(
  parameter int unsigned CHUNK_BYTES = 180
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  csws_pkg::item_t   item_i,
  output csws_pkg::res_t    res_o
);

  localparam logic [24:0] CHUNK25  = 25'(CHUNK_BYTES);
  localparam logic [23:0] CHUNK24  = 24'(CHUNK_BYTES);
  localparam logic [7:0]  CHUNK8   = 8'(CHUNK_BYTES);
  localparam logic [24:0] ROUND_UP = 25'(CHUNK_BYTES - 1);
  localparam logic [23:0] LEN_MAX  = 24'(CHUNK_BYTES * 65535);

  logic        sending_q, sending_d;
  logic        header_done_q, header_done_d;
  logic        wait_ack_q, wait_ack_d;
  logic        connected_q, connected_d;
  logic [15:0] next_seq_q, next_seq_d;
  logic [15:0] packet_total_q, packet_total_d;
  logic [23:0] byte_offset_q, byte_offset_d;
  logic [23:0] total_length_q, total_length_d;

  logic [24:0] dividend;
  logic [24:0] est_back;
  logic [24:0] rem;
  logic [24:0] count;
  logic [23:0] remain;
  logic [7:0]  plen;

  // Fix the reciprocal estimate up by one where the remainder still holds a chunk.
  assign dividend = {1'b0, item_i.len} + ROUND_UP;
  assign est_back = 25'(item_i.quot_est * CHUNK25);
  assign rem      = dividend - est_back;
  assign count    = item_i.quot_est + ((rem >= CHUNK25) ? 25'd1 : 25'd0);

  assign remain = total_length_q - byte_offset_q;
  assign plen   = (remain < CHUNK24) ? remain[7:0] : CHUNK8;

  always_comb begin
    sending_d      = sending_q;
    header_done_d  = header_done_q;
    wait_ack_d     = wait_ack_q;
    connected_d    = connected_q;
    next_seq_d     = next_seq_q;
    packet_total_d = packet_total_q;
    byte_offset_d  = byte_offset_q;
    total_length_d = total_length_q;
    res_o          = '0;
    case (item_i.req)
      csws_pkg::REQ_START: begin
        if (connected_q && (item_i.len <= LEN_MAX)) begin
          total_length_d = item_i.len;
          byte_offset_d  = '0;
          next_seq_d     = '0;
          packet_total_d = count[15:0];
          sending_d      = 1'b1;
          header_done_d  = 1'b0;
          wait_ack_d     = 1'b0;
        end
      end
      csws_pkg::REQ_ACK: begin
        if ((item_i.ack == next_seq_q) || (item_i.ack == csws_pkg::SEQ_ANY)) begin
          wait_ack_d = 1'b0;
        end
      end
      csws_pkg::REQ_POLL: begin
        if (sending_q && connected_q && !wait_ack_q) begin
          if (!header_done_q) begin
            res_o.pkt_valid   = 1'b1;
            res_o.pkt_kind    = csws_pkg::KIND_HDR;
            res_o.hdr_length  = total_length_q;
            res_o.hdr_packets = packet_total_q;
            header_done_d     = 1'b1;
            wait_ack_d        = 1'b1;
          end else begin
            if (next_seq_q < packet_total_q) begin
              res_o.pkt_valid  = 1'b1;
              res_o.pkt_kind   = csws_pkg::KIND_DATA;
              res_o.pkt_seq    = next_seq_q;
              res_o.pkt_offset = byte_offset_q;
              res_o.pkt_len    = plen;
              byte_offset_d    = byte_offset_q + {16'd0, plen};
              wait_ack_d       = 1'b1;
              next_seq_d       = next_seq_q + 16'd1;
            end
            // End on the last packet (ack still awaited) or after an empty header.
            if (next_seq_d >= packet_total_q) begin
              sending_d           = 1'b0;
              res_o.transfer_done = 1'b1;
            end
          end
        end
      end
      csws_pkg::REQ_LINK: begin
        connected_d = item_i.link;
      end
      default: begin
      end
    endcase
    res_o.busy_res     = sending_d;
    res_o.awaiting_ack = wait_ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q      <= 1'b0;
      header_done_q  <= 1'b0;
      wait_ack_q     <= 1'b0;
      connected_q    <= 1'b0;
      next_seq_q     <= '0;
      packet_total_q <= '0;
      byte_offset_q  <= '0;
      total_length_q <= '0;
    end else if (fire_i) begin
      sending_q      <= sending_d;
      header_done_q  <= header_done_d;
      wait_ack_q     <= wait_ack_d;
      connected_q    <= connected_d;
      next_seq_q     <= next_seq_d;
      packet_total_q <= packet_total_d;
      byte_offset_q  <= byte_offset_d;
      total_length_q <= total_length_d;
    end
  end

endmodule

[sv/chunked_stop_and_wait_sender_top.sv]
// Chunked stop-and-wait sender: turns start, ack, poll and link events into
// packet descriptors. Depends on csws_pkg, csws_recip and csws_core.
//
// One result beat comes out for every input beat, in order. The block takes a
// beat every cycle while the result side does not stall. A beat passes through
// two registers: an input register, which also holds the reciprocal-multiply
// estimate of the packet count, and a result register, from which the result
// is presented. The count correction and the transfer state update sit between
// the two, and the state advances as each beat moves into the result register.
// CHUNK_BYTES sets the payload size per packet (1 to 255); a start whose
// length would need more than 65535 packets is dropped, as is a start while
// the link is down.
module chunked_stop_and_wait_sender_top #(
  parameter int unsigned CHUNK_BYTES = 180
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // image_length[23:0], ack_seq[39:24], link_up[40], zero fill
  input  logic [csws_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // req_type[1:0]
  input  logic [csws_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // pkt_valid[0], pkt_seq[16:1], pkt_offset[40:17], pkt_len[48:41],
  // hdr_length[72:49], hdr_packets[88:73], transfer_done[89], busy_res[90],
  // awaiting_ack[91], zero fill
  output logic [csws_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // pkt_kind[0]
  output logic [csws_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);

  logic             in_valid_q;
  csws_pkg::item_t  in_item_q;
  logic             out_valid_q;
  csws_pkg::res_t   out_res_q;

  logic             in_fire;
  logic             advance;
  logic [24:0]      quot_est;
  csws_pkg::res_t   step_res;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  csws_recip #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_recip (
    .len_i      (s_axis_tdata_i[23:0]),
    .quot_est_o (quot_est)
  );

  csws_core #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_item_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on the beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.req      <= csws_pkg::req_e'(s_axis_tuser_i);
      in_item_q.len      <= s_axis_tdata_i[23:0];
      in_item_q.ack      <= s_axis_tdata_i[39:24];
      in_item_q.link     <= s_axis_tdata_i[40];
      in_item_q.quot_est <= quot_est;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.pkt_kind;
  assign m_axis_tdata_o  = {4'd0,
                            out_res_q.awaiting_ack,
                            out_res_q.busy_res,
                            out_res_q.transfer_done,
                            out_res_q.hdr_packets,
                            out_res_q.hdr_length,
                            out_res_q.pkt_len,
                            out_res_q.pkt_offset,
                            out_res_q.pkt_seq,
                            out_res_q.pkt_valid};

endmodule

[test/csws_desc_checker.sv]
`timescale 1ns / 100ps
// Descriptor checker for chunked_stop_and_wait_sender_top: predicts one result beat per
// request beat and compares the result stream in order. Depends on csws_pkg.
module csws_desc_checker #(
  parameter int unsigned CHUNK_BYTES = 180
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  input  logic [csws_pkg::IN_DATA_W-1:0]     s_tdata_i,
  input  logic [csws_pkg::IN_USER_W-1:0]     s_tuser_i,
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  input  logic [csws_pkg::OUT_DATA_W-1:0]    m_tdata_i,
  input  logic [csws_pkg::OUT_USER_W-1:0]    m_tuser_i,
  output int                                 err_count_o,
  output int                                 pending_o
);
  import csws_pkg::*;

  localparam int unsigned LEN_LIMIT = CHUNK_BYTES * 65535;

  // Predicted sender state
  logic        sending_q;
  logic        hdr_sent_q;
  logic        wait_ack_q;
  logic        link_q;
  logic [15:0] next_seq_q;
  logic [15:0] pkt_total_q;
  logic [23:0] offset_q;
  logic [23:0] img_len_q;

  res_t desc_q[$];
  int   n_errors = 0;
  int   n_pending = 0;

  assign err_count_o = n_errors;
  assign pending_o   = n_pending;

  function automatic res_t predict_desc(req_e rq, logic [23:0] len, logic [15:0] ack,
                                        logic lnk);
    res_t        r;
    logic [23:0] remain;
    logic [7:0]  plen;
    r = '0;
    case (rq)
      REQ_START: begin
        if (link_q && len <= LEN_LIMIT) begin
          img_len_q   = len;
          offset_q    = '0;
          next_seq_q  = '0;
          pkt_total_q = 16'((32'(len) + CHUNK_BYTES - 1) / CHUNK_BYTES);
          sending_q   = 1'b1;
          hdr_sent_q  = 1'b0;
          wait_ack_q  = 1'b0;
        end
      end
      REQ_ACK: begin
        if (ack == next_seq_q || ack == SEQ_ANY) wait_ack_q = 1'b0;
      end
      REQ_POLL: begin
        if (sending_q && link_q && !wait_ack_q) begin
          if (!hdr_sent_q) begin
            r.pkt_valid   = 1'b1;
            r.pkt_kind    = KIND_HDR;
            r.hdr_length  = img_len_q;
            r.hdr_packets = pkt_total_q;
            hdr_sent_q    = 1'b1;
            wait_ack_q    = 1'b1;
          end else begin
            if (next_seq_q < pkt_total_q) begin
              remain       = img_len_q - offset_q;
              plen         = (remain < CHUNK_BYTES) ? remain[7:0] : 8'(CHUNK_BYTES);
              r.pkt_valid  = 1'b1;
              r.pkt_kind   = KIND_DATA;
              r.pkt_seq    = next_seq_q;
              r.pkt_offset = offset_q;
              r.pkt_len    = plen;
              offset_q     = offset_q + 24'(plen);
              wait_ack_q   = 1'b1;
              next_seq_q   = next_seq_q + 16'd1;
            end
            // close the transfer on its last packet, or on the poll after an empty header
            if (next_seq_q >= pkt_total_q) begin
              sending_q       = 1'b0;
              r.transfer_done = 1'b1;
            end
          end
        end
      end
      default: link_q = lnk;
    endcase
    r.busy_res     = sending_q;
    r.awaiting_ack = wait_ack_q;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    res_t want;
    if (!rst_ni) begin
      sending_q   = 1'b0;
      hdr_sent_q  = 1'b0;
      wait_ack_q  = 1'b0;
      link_q      = 1'b0;
      next_seq_q  = '0;
      pkt_total_q = '0;
      offset_q    = '0;
      img_len_q   = '0;
      desc_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        desc_q.push_back(predict_desc(req_e'(s_tuser_i), s_tdata_i[23:0], s_tdata_i[39:24],
                                      s_tdata_i[40]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (desc_q.size() == 0) begin
          $error("result beat with no request beat pending");
          n_errors++;
        end else begin
          want = desc_q.pop_front();
          check_field("pkt_valid", want.pkt_valid, m_tdata_i[0]);
          check_field("pkt_kind", want.pkt_kind, m_tuser_i[0]);
          check_field("pkt_seq", want.pkt_seq, m_tdata_i[16:1]);
          check_field("pkt_offset", want.pkt_offset, m_tdata_i[40:17]);
          check_field("pkt_len", want.pkt_len, m_tdata_i[48:41]);
          check_field("hdr_length", want.hdr_length, m_tdata_i[72:49]);
          check_field("hdr_packets", want.hdr_packets, m_tdata_i[88:73]);
          check_field("transfer_done", want.transfer_done, m_tdata_i[89]);
          check_field("busy_res", want.busy_res, m_tdata_i[90]);
          check_field("awaiting_ack", want.awaiting_ack, m_tdata_i[91]);
        end
      end
    end
    n_pending = desc_q.size();
  end

endmodule

[test/chunked_stop_and_wait_sender_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for chunked_stop_and_wait_sender_top: drives request beats and result
// backpressure, gives the verdict. Depends on csws_pkg and csws_desc_checker.
module chunked_stop_and_wait_sender_top_tb;
  import csws_pkg::*;

  localparam int unsigned CHUNK_BYTES = 180;
  localparam int unsigned LEN_LIMIT   = CHUNK_BYTES * 65535;
  localparam int          N_ITEMS     = 1050;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  int err_count;
  int pending;
  int n_items = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;
  bit link_state = 1'b0;

  chunked_stop_and_wait_sender_top #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  csws_desc_checker #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off per request
  initial begin : rx_side
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 79;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Entered and left at a falling edge; valid stays high across back-to-back beats.
  task automatic send_beat(req_e rq, logic [23:0] len, logic [15:0] ack, logic lnk);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 41){1'b0}}, lnk, ack, len};
    s_axis_tuser  <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_items++;
    if (rq == REQ_LINK) link_state = lnk;
  endtask

  task automatic do_start(logic [23:0] len);
    send_beat(REQ_START, len, 16'($urandom), 1'($urandom));
  endtask

  task automatic do_ack(logic [15:0] ack);
    send_beat(REQ_ACK, 24'($urandom), ack, 1'($urandom));
  endtask

  task automatic do_poll();
    send_beat(REQ_POLL, 24'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic do_link(logic lnk);
    send_beat(REQ_LINK, 24'($urandom), 16'($urandom), lnk);
  endtask

  // Drop valid and hold until every predicted result beat has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // One well-formed image transfer with random disturbances; stops after at most max_pkts + 1 data packets.
  task automatic run_transfer(logic [23:0] len, int max_pkts);
    int          npk;
    int          r;
    logic [15:0] seq_ack;
    if (!link_state) do_link(1'b1);
    do_start(len);
    do_poll();
    if (len > LEN_LIMIT) return;
    npk = (int'(len) + CHUNK_BYTES - 1) / CHUNK_BYTES;
    for (int i = 0; i <= npk; i++) begin
      if (i > max_pkts) return;
      seq_ack = 16'(i);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        do_poll();
      end else if (r < 14) begin
        do_ack(seq_ack + 16'($urandom_range(1, 100)));
        do_poll();
      end else if (r < 18) begin
        do_link(1'b0);
        do_poll();
        do_link(1'b1);
      end else if (r < 20) begin
        return;
      end
      do_ack((r >= 90) ? SEQ_ANY : seq_ack);
      if (i < npk || npk == 0) do_poll();
    end
  endtask

  initial begin : stim
    int          r;
    logic [23:0] len;
    int          max_pkts;
    bit          held_mid;
    bit          paused;
    held_mid = 1'b0;
    paused   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle poll, start with link down, empty image, short tail packet,
    // blocked polls, wrong ack, link drop mid-transfer, length limit, restart.
    do_poll();
    do_start(24'd100);
    do_link(1'b1);
    do_start(24'd0);
    do_poll();
    do_ack(16'd0);
    do_poll();
    do_start(24'd181);
    do_poll();
    do_poll();
    do_ack(16'd5);
    do_ack(16'd0);
    do_poll();
    do_link(1'b0);
    do_ack(16'd1);
    do_poll();
    do_link(1'b1);
    do_poll();
    do_ack(SEQ_ANY);
    do_start(24'(LEN_LIMIT));
    do_poll();
    do_start(24'(LEN_LIMIT + 1));
    do_start(24'hFFFFFF);
    do_ack(16'd0);
    do_poll();
    do_start(24'd360);
    do_poll();

    // Random: mostly well-formed transfers, some raw noise beats
    hold_req = 1'b1;
    while (n_items < N_ITEMS) begin
      idle_en = (n_items < N_ITEMS - 150) && ($urandom_range(0, 3) != 0);
      if (!held_mid && n_items > 500) begin
        held_mid = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && n_items > 700) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4))
          send_beat(req_e'($urandom_range(0, 3)), 24'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        max_pkts = 1000;
        if (r < 10) begin
          len = '0;
        end else if (r < 45) begin
          len = 24'($urandom_range(1, 540));
        end else if (r < 60) begin
          len = 24'(CHUNK_BYTES * $urandom_range(1, 6));
        end else if (r < 85) begin
          len = 24'($urandom_range(541, 2000));
        end else if (r < 93) begin
          // big image: send only the first few packets, then move on
          len = 24'($urandom_range(2001, LEN_LIMIT));
          max_pkts = 4;
        end else begin
          len = 24'($urandom_range(LEN_LIMIT + 1, 24'hFFFFFF));
        end
        run_transfer(len, max_pkts);
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
